// File: design/float_to_int8_affine_quantizer_defines.svh
// Assertion macros shared by the quantizer RTL
`ifndef FLOAT_TO_INT8_AFFINE_QUANTIZER_DEFINES_SVH
`define FLOAT_TO_INT8_AFFINE_QUANTIZER_DEFINES_SVH

// same-cycle implication, checked on every clock outside reset
`define F2IQ_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("quantizer check failed");

// next-cycle implication, checked on every clock outside reset
`define F2IQ_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("quantizer check failed");

`endif

// File: design/f2i8q_pkg.sv
// Types and constants shared by the quantizer pipeline
package f2i8q_pkg;

    localparam logic [1:0] CFG_SCALE = 2'd0;
    localparam logic [1:0] CFG_ZERO  = 2'd1;
    localparam logic [1:0] CFG_LOW   = 2'd2;
    localparam logic [1:0] CFG_HIGH  = 2'd3;

    localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;

    typedef struct packed {
        logic [31:0]        scale;
        logic signed [7:0]  zero;
        logic signed [7:0]  low;
        logic signed [7:0]  high;
    } t_cfg;

    // raw product: value = mant * 2^exp
    typedef struct packed {
        logic               nan;
        logic               inf;
        logic               zero;
        logic               sign;
        logic signed [10:0] exp;
        logic [47:0]        mant;
    } t_prod;

    // leading one located: exp is the weight of the leading bit
    typedef struct packed {
        logic               nan;
        logic               inf;
        logic               zero;
        logic               sign;
        logic signed [10:0] exp;
        logic [5:0]         shamt;
        logic [47:0]        mant;
    } t_lead;

    // fp32 product: value = sig * 2^(exp-23), sig[23] set
    typedef struct packed {
        logic               nan;
        logic               inf;
        logic               zero;
        logic               sign;
        logic signed [10:0] exp;
        logic [23:0]        sig;
    } t_fp;

    // integer magnitude after rounding
    typedef struct packed {
        logic       sat;
        logic       sign;
        logic [9:0] mag;
    } t_int;

endpackage

// File: design/f2i8q_cfg.sv
// Configuration register file
module f2i8q_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    output f2i8q_pkg::t_cfg   o_cfg
);
    import f2i8q_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale <= SCALE_RESET;
            r_cfg.zero  <= 8'sd0;
            r_cfg.low   <= -8'sd128;
            r_cfg.high  <= 8'sd127;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SCALE: r_cfg.scale <= i_cfg_data;
                CFG_ZERO:  r_cfg.zero  <= i_cfg_data[7:0];
                CFG_LOW:   r_cfg.low   <= i_cfg_data[7:0];
                CFG_HIGH:  r_cfg.high  <= i_cfg_data[7:0];
                default:   r_cfg.scale <= r_cfg.scale;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;
endmodule

// File: design/f2i8q_mul.sv
// Stage 1: unpack both operands and multiply the significands
module f2i8q_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  logic [31:0]       i_sample,
    input  logic [31:0]       i_scale,
    output logic              o_valid,
    output f2i8q_pkg::t_prod  o_prod
);
    import f2i8q_pkg::*;

    logic        r_valid;
    t_prod       r_prod;
    t_prod       n_prod;
    logic [7:0]  ex, es;
    logic [22:0] fx, fs;
    logic        nanx, nans, infx, infs, zerx, zers;
    logic signed [10:0] eux, eus;

    always_comb begin
        ex   = i_sample[30:23];
        fx   = i_sample[22:0];
        es   = i_scale[30:23];
        fs   = i_scale[22:0];
        nanx = (ex == 8'hFF) && (fx != 23'd0);
        nans = (es == 8'hFF) && (fs != 23'd0);
        infx = (ex == 8'hFF) && (fx == 23'd0);
        infs = (es == 8'hFF) && (fs == 23'd0);
        zerx = (ex == 8'd0) && (fx == 23'd0);
        zers = (es == 8'd0) && (fs == 23'd0);
        // subnormals carry the minimum exponent with no hidden bit
        eux  = (ex == 8'd0) ? -11'sd126 : $signed({3'b000, ex}) - 11'sd127;
        eus  = (es == 8'd0) ? -11'sd126 : $signed({3'b000, es}) - 11'sd127;

        n_prod.nan  = nanx | nans | (infx & zers) | (infs & zerx);
        n_prod.inf  = (infx | infs) & ~n_prod.nan;
        n_prod.zero = zerx | zers;
        n_prod.sign = i_sample[31] ^ i_scale[31];
        n_prod.exp  = eux + eus - 11'sd46;
        n_prod.mant = {(ex != 8'd0), fx} * {(es != 8'd0), fs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;
endmodule

// File: design/f2i8q_norm.sv
// Stages 2 and 3: find the leading one, normalize and round to fp32
module f2i8q_norm (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  f2i8q_pkg::t_prod  i_prod,
    output logic              o_valid,
    output f2i8q_pkg::t_fp    o_fp
);
    import f2i8q_pkg::*;

    logic        r_valid_a, r_valid_b;
    t_lead       r_lead, n_lead;
    t_fp         r_fp, n_fp;
    logic [5:0]  lead;
    logic [47:0] norm;
    logic        up;
    logic [24:0] rsum;

    always_comb begin
        lead = 6'd0;
        for (int i = 0; i < 48; i++) begin
            if (i_prod.mant[i]) begin
                lead = 6'(i);
            end
        end
        n_lead.nan   = i_prod.nan;
        n_lead.inf   = i_prod.inf;
        n_lead.zero  = i_prod.zero;
        n_lead.sign  = i_prod.sign;
        n_lead.exp   = i_prod.exp + $signed({5'b00000, lead});
        n_lead.shamt = 6'd47 - lead;
        n_lead.mant  = i_prod.mant;
    end

    always_comb begin
        norm = r_lead.mant << r_lead.shamt;
        // round to 24 significant bits, nearest even
        up   = norm[23] & ((|norm[22:0]) | norm[24]);
        rsum = {1'b0, norm[47:24]} + {24'd0, up};
        n_fp.nan  = r_lead.nan;
        n_fp.inf  = r_lead.inf;
        n_fp.zero = r_lead.zero;
        n_fp.sign = r_lead.sign;
        if (rsum[24]) begin
            n_fp.sig = 24'h80_0000;
            n_fp.exp = r_lead.exp + 11'sd1;
        end else begin
            n_fp.sig = rsum[23:0];
            n_fp.exp = r_lead.exp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else if (i_adv) begin
            r_valid_a <= i_valid;
            r_valid_b <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_lead <= n_lead;
            r_fp   <= n_fp;
        end
    end

    assign o_valid = r_valid_b;
    assign o_fp    = r_fp;
endmodule

// File: design/f2i8q_round.sv
// Stages 4 and 5: round to integer, add the zero point and clamp
module f2i8q_round (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  f2i8q_pkg::t_fp    i_fp,
    input  f2i8q_pkg::t_cfg   i_cfg,
    output logic              o_valid,
    output logic [7:0]        o_code
);
    import f2i8q_pkg::*;

    logic               r_valid_a, r_valid_b;
    t_int               r_int, n_int;
    logic [7:0]         r_code, n_code;
    logic               tiny, big;
    logic signed [10:0] kexp;
    logic [34:0]        fix;
    logic               up;
    logic signed [11:0] rv, q, qlo;

    always_comb begin
        tiny = (i_fp.exp < -11'sd2) | i_fp.zero | i_fp.nan;
        big  = (i_fp.exp > 11'sd9) | ((i_fp.exp == 11'sd9) && (i_fp.sig[22:0] != 23'd0));
        kexp = i_fp.exp + 11'sd2;
        // 25 fraction bits after the shift
        fix  = {11'd0, i_fp.sig} << kexp[3:0];
        up   = fix[24] & ((|fix[23:0]) | fix[25]);
        n_int.sat  = (big | i_fp.inf) & ~i_fp.nan;
        n_int.sign = i_fp.sign;
        n_int.mag  = tiny ? 10'd0 : fix[34:25] + {9'd0, up};
    end

    always_comb begin
        if (r_int.sat) begin
            rv = r_int.sign ? -12'sd1000 : 12'sd1000;
        end else begin
            rv = r_int.sign ? -$signed({2'b00, r_int.mag}) : $signed({2'b00, r_int.mag});
        end
        q   = rv + 12'(i_cfg.zero);
        // low bound first, then high bound
        qlo = (q < 12'(i_cfg.low)) ? 12'(i_cfg.low) : q;
        n_code = (qlo > 12'(i_cfg.high)) ? i_cfg.high : qlo[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else if (i_adv) begin
            r_valid_a <= i_valid;
            r_valid_b <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_int  <= n_int;
            r_code <= n_code;
        end
    end

    assign o_valid = r_valid_b;
    assign o_code  = r_code;
endmodule

// File: design/float_to_int8_affine_quantizer.sv
// Top level of the fp32 to int8 affine quantizer
//
// Input channel: i_valid / o_ready carry one fp32 word in i_sample_bits.
// Output channel: o_valid / i_ready carry one int8 word in o_quantized_code.
// Config channel: i_cfg_valid / o_cfg_ready write i_cfg_data into register
// i_cfg_index (0 reciprocal scale, 1 zero point, 2 low clamp, 3 high clamp);
// o_cfg_ready is always high. Write config only while the pipeline is empty.
// Throughput is one fp32 word per cycle unless the output stalls. The depth
// is set by five register stages: multiply, leading-one search, normalize
// and fp32 round, integer round, clamp.
// Reset empties the pipeline and loads scale 1.0, zero point 0, clamps
// -128 and 127. When the receiver holds i_ready low with a result waiting,
// every stage holds and o_ready drops; nothing is dropped or repeated.
module float_to_int8_affine_quantizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_sample_bits,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_quantized_code,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import f2i8q_pkg::*;
    `include "float_to_int8_affine_quantizer_defines.svh"

    t_cfg  cfg;
    t_prod prod;
    t_fp   fp;
    logic  adv;
    logic  v1, v3;

    // advance the whole pipeline unless the output word is stuck
    assign adv     = ~o_valid | i_ready;
    assign o_ready = adv;

    f2i8q_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    f2i8q_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_valid  (i_valid),
        .i_sample (i_sample_bits),
        .i_scale  (cfg.scale),
        .o_valid  (v1),
        .o_prod   (prod)
    );

    f2i8q_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (v1),
        .i_prod  (prod),
        .o_valid (v3),
        .o_fp    (fp)
    );

    f2i8q_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (v3),
        .i_fp    (fp),
        .i_cfg   (cfg),
        .o_valid (o_valid),
        .o_code  (o_quantized_code)
    );

    `F2IQ_ASSERT_IMP(a_stall_blocks_input, i_clk, i_rst_n, o_valid && !i_ready, !o_ready)
    `F2IQ_ASSERT_NXT(a_accept_enters, i_clk, i_rst_n, i_valid && o_ready, v1)
    `F2IQ_ASSERT_IMP(a_code_in_bounds, i_clk, i_rst_n, o_valid && (cfg.low <= cfg.high), ($signed(o_quantized_code) >= cfg.low) && ($signed(o_quantized_code) <= cfg.high))
endmodule
